// File: design/mlhr_pkg.sv
// ----------------------------------------------------------------------------
// Metric line hash router package
// Shared types, status codes and constants for the router core.
// ----------------------------------------------------------------------------
package mlhr_pkg;

  localparam int unsigned HashW = 64;
  localparam int unsigned LenW  = 13;

  localparam logic [LenW-1:0] LenSat  = 13'd4096;
  localparam logic [LenW-1:0] MaxLine = 13'd1450;
  localparam logic [LenW-1:0] MinLine = 13'd5;
  localparam logic [4:0]      MaxBackends = 5'd16;

  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharColon   = 8'h3A;

  // Reciprocal of three scaled by 2^11; exact for dividends below 2048.
  localparam logic [10:0] Recip3 = 11'd683;

  typedef enum logic [1:0] {
    STATUS_ROUTED   = 2'd0,
    STATUS_BAD_LEN  = 2'd1,
    STATUS_NO_COLON = 2'd2,
    STATUS_ALL_DEAD = 2'd3
  } status_e;

  typedef enum logic {
    CFG_COUNT = 1'b0,
    CFG_ALIVE = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MOD_GO,
    ST_MOD_WAIT,
    ST_RD_J,
    ST_PICK,
    ST_SWAP,
    ST_MIX_GO,
    ST_MIX_WAIT,
    ST_EMIT,
    ST_EMIT2
  } state_e;

  // Request from the sequencer to the shared divider.
  typedef struct packed {
    logic       start;
    logic       by3;
    logic [4:0] divisor;
  } div_ctl_t;

endpackage

// File: design/mlhr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mlhr_ram #(
  parameter int unsigned Width = 4,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/mlhr_div.sv
// ----------------------------------------------------------------------------
// Shared divider
// Restoring division of a 64-bit word by a small divisor, one bit a cycle, or
// division by three one byte a cycle through a reciprocal multiply.
// ----------------------------------------------------------------------------
module mlhr_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mlhr_pkg::div_ctl_t          ctl_i,
  input  logic [mlhr_pkg::HashW-1:0]  dividend_i,
  output logic                        done_o,
  output logic                        busy_o,
  output logic [mlhr_pkg::HashW-1:0]  quot_o,
  output logic [4:0]                  rem_o
);
  import mlhr_pkg::*;

  logic [HashW-1:0] quo_q, quo_d;
  logic [4:0]       rem_q, rem_d;
  logic [4:0]       dvs_q, dvs_d;
  logic [5:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic             by3_q, by3_d;
  logic [5:0]       trial;
  logic             ge;
  logic [9:0]       part3;
  logic [19:0]      prod3;
  logic [7:0]       q3;
  logic [9:0]       back3;
  logic [9:0]       diff3;

  assign trial = {rem_q, quo_q[HashW-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  // Byte step of the divide by three: the running remainder (below three)
  // and the next byte form a value below 768, so the scaled reciprocal gives
  // its exact quotient digit.
  assign part3 = {rem_q[1:0], quo_q[HashW-1 -: 8]};
  assign prod3 = 20'(part3) * 20'(Recip3);
  assign q3    = prod3[18:11];
  assign back3 = {1'b0, q3, 1'b0} + {2'b00, q3};
  assign diff3 = part3 - back3;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    by3_d  = by3_q;
    done_d = 1'b0;
    if (ctl_i.start) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = ctl_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
      by3_d  = ctl_i.by3;
    end else if (busy_q) begin
      cnt_d = cnt_q + 6'd1;
      if (by3_q) begin
        quo_d = {quo_q[HashW-9:0], q3};
        rem_d = {3'b000, diff3[1:0]};
        if (cnt_q == 6'd7) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end else begin
        quo_d = {quo_q[HashW-2:0], ge};
        rem_d = ge ? 5'(trial - {1'b0, dvs_q}) : trial[4:0];
        if (cnt_q == 6'd63) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    by3_q <= by3_d;
  end

  assign done_o = done_q;
  assign busy_o = busy_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

// File: design/metric_line_hash_router_core.sv
// ----------------------------------------------------------------------------
// Metric line hash router core
// Splits datagram bytes into lines, hashes the metric name and picks a
// healthy backend by shuffled probing.
// ----------------------------------------------------------------------------
// Sequence: a byte that ends no line is absorbed without a stall. A rejected
//   line passes through the check and emit states. Each probe runs the
//   64-step remainder, the order read and the pick; a dead probe adds a swap
//   (unless it sits at the window's end) and the 8-step remix by three.
// Throughput: one byte per cycle inside a line; the block stalls input while
//   a line end is being resolved and delivered.
// Reset: asynchronous, active low; clears line state, count register to 1,
//   alive mask to 0, and all probe-order valid bits.
module metric_line_hash_router_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration write port.
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [15:0]                cfg_data_i,
  // Input beats.
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 data_byte_i,
  input  logic                       end_of_datagram_i,
  // Result beats.
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 route_status_o,
  output logic [3:0]                 backend_index_o,
  output logic [mlhr_pkg::LenW-1:0]  line_len_o,
  output logic                       last_of_run_o
);
  import mlhr_pkg::*;

  // Configuration registers.
  logic [4:0]  cfg_count_q;
  logic [15:0] alive_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_count_q <= 5'd1;
      alive_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_COUNT: cfg_count_q <= cfg_data_i[4:0];
        CFG_ALIVE: alive_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  state_e state_q, state_d;

  // Running line state.
  logic [HashW-1:0] name_hash_q, name_hash_d;
  logic [LenW-1:0]  line_cnt_q, line_cnt_d;
  logic             colon_q, colon_d;

  // Line being resolved.
  logic [HashW-1:0] fin_hash_q, fin_hash_d;
  logic [LenW-1:0]  fin_len_q, fin_len_d;
  logic             fin_colon_q, fin_colon_d;
  logic             extra_q, extra_d;
  status_e          res_status_q, res_status_d;
  logic [3:0]       res_backend_q, res_backend_d;

  // Probe state.
  logic [HashW-1:0] probe_hash_q, probe_hash_d;
  logic [4:0]       remain_q, remain_d;
  logic [3:0]       j_q, j_d;
  logic [15:0]      ord_vld_q, ord_vld_d;
  logic             rd_vld_q;
  logic [3:0]       rd_addr_q;

  // Output register.
  logic             out_valid_q, out_valid_d;
  status_e          out_status_q, out_status_d;
  logic [3:0]       out_backend_q, out_backend_d;
  logic [LenW-1:0]  out_len_q, out_len_d;
  logic             out_last_q, out_last_d;

  // Divider and RAM hookup.
  div_ctl_t         div_ctl;
  logic [HashW-1:0] div_dividend;
  logic             div_done;
  logic             div_busy;
  logic [HashW-1:0] div_quot;
  logic [4:0]       div_rem;
  logic             ram_we;
  logic [3:0]       ram_raddr;
  logic [3:0]       ram_rdata;
  logic [3:0]       order_val;

  mlhr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .dividend_i (div_dividend),
    .done_o     (div_done),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Probe order table; an entry without its valid bit reads as its own index,
  // which gives the identity order at the start of every selection.
  mlhr_ram #(.Width(4), .Depth(16)) u_order (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (j_q),
    .wdata_i (order_val),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign order_val = rd_vld_q ? ram_rdata : rd_addr_q;

  // Byte handling in the idle state.
  logic             in_acc;
  logic             is_nl;
  logic [LenW-1:0]  cnt_inc1;
  logic [LenW-1:0]  cnt_inc2;
  logic [HashW-1:0] hash_upd;
  logic [HashW-1:0] hash_nx;
  logic             colon_nx;
  logic             line_end;
  logic             len_ok;
  logic [4:0]       eff_count;
  logic             out_free;
  logic [3:0]       last_pos;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign is_nl      = (data_byte_i == CharNewline);
  assign cnt_inc1   = (line_cnt_q == LenSat) ? line_cnt_q : line_cnt_q + 13'd1;
  assign cnt_inc2   = (cnt_inc1 == LenSat) ? cnt_inc1 : cnt_inc1 + 13'd1;
  assign hash_upd   = (name_hash_q << 5) - name_hash_q
                      + {{(HashW-8){data_byte_i[7]}}, data_byte_i};
  assign hash_nx    = (!is_nl && !colon_q && data_byte_i != CharColon)
                      ? hash_upd : name_hash_q;
  assign colon_nx   = colon_q || (!is_nl && data_byte_i == CharColon);
  assign line_end   = is_nl || end_of_datagram_i;
  assign len_ok     = (fin_len_q > MinLine) && (fin_len_q < MaxLine);
  assign eff_count  = (cfg_count_q > MaxBackends) ? MaxBackends : cfg_count_q;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign last_pos   = 4'(remain_q - 5'd1);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_acc && line_end) state_d = ST_CHECK;
      ST_CHECK: begin
        if (!len_ok || !fin_colon_q || eff_count == 5'd0) state_d = ST_EMIT;
        else                                              state_d = ST_MOD_GO;
      end
      ST_MOD_GO:   state_d = ST_MOD_WAIT;
      ST_MOD_WAIT: if (div_done) state_d = ST_RD_J;
      ST_RD_J:     state_d = ST_PICK;
      ST_PICK: begin
        if (alive_q[order_val])   state_d = ST_EMIT;
        else if (j_q != last_pos) state_d = ST_SWAP;
        else                      state_d = ST_MIX_GO;
      end
      ST_SWAP:     state_d = ST_MIX_GO;
      ST_MIX_GO:   state_d = ST_MIX_WAIT;
      ST_MIX_WAIT: begin
        if (div_done) state_d = (remain_q == 5'd1) ? ST_EMIT : ST_MOD_GO;
      end
      ST_EMIT:     if (out_free) state_d = extra_q ? ST_EMIT2 : ST_IDLE;
      ST_EMIT2:    if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    name_hash_d   = name_hash_q;
    line_cnt_d    = line_cnt_q;
    colon_d       = colon_q;
    fin_hash_d    = fin_hash_q;
    fin_len_d     = fin_len_q;
    fin_colon_d   = fin_colon_q;
    extra_d       = extra_q;
    res_status_d  = res_status_q;
    res_backend_d = res_backend_q;
    probe_hash_d  = probe_hash_q;
    remain_d      = remain_q;
    j_d           = j_q;
    ord_vld_d     = ord_vld_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_status_d  = out_status_q;
    out_backend_d = out_backend_q;
    out_len_d     = out_len_q;
    out_last_d    = out_last_q;
    div_ctl       = '{start: 1'b0, by3: 1'b0, divisor: remain_q};
    div_dividend  = probe_hash_q;
    ram_we        = 1'b0;
    ram_raddr     = j_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (line_end) begin
            // A newline byte closes the line at its count; an implied newline
            // after an ordinary last byte adds one more count.
            fin_hash_d  = hash_nx;
            fin_colon_d = colon_nx;
            fin_len_d   = is_nl ? cnt_inc1 : cnt_inc2;
            extra_d     = is_nl && end_of_datagram_i;
            name_hash_d = '0;
            line_cnt_d  = '0;
            colon_d     = 1'b0;
          end else begin
            name_hash_d = hash_nx;
            line_cnt_d  = cnt_inc1;
            colon_d     = colon_nx;
          end
        end
      end
      ST_CHECK: begin
        res_backend_d = '0;
        if (!len_ok) begin
          res_status_d = STATUS_BAD_LEN;
        end else if (!fin_colon_q) begin
          res_status_d = STATUS_NO_COLON;
        end else if (eff_count == 5'd0) begin
          res_status_d = STATUS_ALL_DEAD;
        end else begin
          probe_hash_d = fin_hash_q;
          remain_d     = eff_count;
          ord_vld_d    = '0;
        end
      end
      ST_MOD_GO: begin
        div_ctl = '{start: 1'b1, by3: 1'b0, divisor: remain_q};
      end
      ST_MOD_WAIT: begin
        if (div_done) j_d = div_rem[3:0];
      end
      ST_RD_J: begin
        ram_raddr = j_q;
      end
      ST_PICK: begin
        ram_raddr = last_pos;
        if (alive_q[order_val]) begin
          res_status_d  = STATUS_ROUTED;
          res_backend_d = order_val;
        end
      end
      ST_SWAP: begin
        // The dead candidate moves past the live window, so only the slot
        // it leaves needs the entry that sat at the window's end.
        ram_we         = 1'b1;
        ord_vld_d[j_q] = 1'b1;
      end
      ST_MIX_GO: begin
        div_ctl      = '{start: 1'b1, by3: 1'b1, divisor: remain_q};
        div_dividend = (probe_hash_q << 3) - probe_hash_q + 64'd5;
      end
      ST_MIX_WAIT: begin
        if (div_done) begin
          probe_hash_d = div_quot;
          remain_d     = remain_q - 5'd1;
          if (remain_q == 5'd1) begin
            res_status_d  = STATUS_ALL_DEAD;
            res_backend_d = '0;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_status_d  = res_status_q;
          out_backend_d = res_backend_q;
          out_len_d     = fin_len_q;
          out_last_d    = !extra_q;
        end
      end
      ST_EMIT2: begin
        // The implied newline after a trailing newline is a one-byte line.
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_status_d  = STATUS_BAD_LEN;
          out_backend_d = '0;
          out_len_d     = 13'd1;
          out_last_d    = 1'b1;
          extra_d       = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      name_hash_q <= '0;
      line_cnt_q  <= '0;
      colon_q     <= 1'b0;
      extra_q     <= 1'b0;
      remain_q    <= '0;
      probe_hash_q <= '0;
      ord_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      name_hash_q <= name_hash_d;
      line_cnt_q  <= line_cnt_d;
      colon_q     <= colon_d;
      extra_q     <= extra_d;
      remain_q    <= remain_d;
      probe_hash_q <= probe_hash_d;
      ord_vld_q   <= ord_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fin_hash_q    <= fin_hash_d;
    fin_len_q     <= fin_len_d;
    fin_colon_q   <= fin_colon_d;
    res_status_q  <= res_status_d;
    res_backend_q <= res_backend_d;
    j_q           <= j_d;
    rd_vld_q      <= ord_vld_q[ram_raddr];
    rd_addr_q     <= ram_raddr;
    out_status_q  <= out_status_d;
    out_backend_q <= out_backend_d;
    out_len_q     <= out_len_d;
    out_last_q    <= out_last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign route_status_o  = out_status_q;
  assign backend_index_o = out_backend_q;
  assign line_len_o      = out_len_q;
  assign last_of_run_o   = out_last_q;

  // A routed line always names a backend that is marked healthy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && route_status_o == STATUS_ROUTED |-> alive_q[backend_index_o])
    else $error("routed to a dead backend");

  // The divider only runs while a selection is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !div_busy)
    else $error("divider busy while idle");

  // The probe window never exceeds the backend limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    remain_q <= MaxBackends)
    else $error("probe window too large");

endmodule
